// ===== src/atmc_pkg.sv =====
// shared types, constants and tables for the accelerometer tilt calibrator
`timescale 1ns / 1ps
`default_nettype none
package atmc_pkg;

    localparam int SAMPLES_DEF    = 99;
    localparam int ACCEL_BITS_DEF = 16;
    localparam int FRAC_BITS      = 8;
    localparam int CW             = 36;   // cordic x/y width
    localparam int AW             = 38;   // angle width, 2^-32 rad units

    localparam logic signed [AW-1:0] PI_Q = AW'(64'sd13493037705);

    typedef enum logic [1:0] {
        K_STORE,
        K_CALIB,
        K_HOLD
    } item_kind_t;

    typedef enum logic [1:0] {
        PH_ROLL,
        PH_PITCH,
        PH_YAW
    } ang_phase_t;

    typedef enum logic [3:0] {
        A_IDLE,
        A_SQA,
        A_SQB,
        A_SQRT,
        A_CSET,
        A_CORDIC,
        A_SCALE,
        A_ROUND,
        A_FIN
    } ang_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_RDC,
        M_LDC,
        M_SWEEP,
        M_TAIL,
        M_EVAL,
        M_AVG,
        M_FIN
    } med_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ANGLE,
        B_MEDIAN,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic signed [9:0] roll;
        logic signed [9:0] pitch;
        logic signed [9:0] yaw;
    } angle_set_t;

    typedef struct packed {
        logic start;
        logic wr_en;
    } med_ctrl_t;

    // atan(2^-i) scaled by 2^32
    function automatic logic signed [AW-1:0] atan_step(input logic [4:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0:    r = AW'(64'sd3373259426);
            5'd1:    r = AW'(64'sd1991351318);
            5'd2:    r = AW'(64'sd1052175346);
            5'd3:    r = AW'(64'sd534100635);
            5'd4:    r = AW'(64'sd268086748);
            5'd5:    r = AW'(64'sd134174063);
            5'd6:    r = AW'(64'sd67103403);
            5'd7:    r = AW'(64'sd33553749);
            5'd8:    r = AW'(64'sd16777131);
            5'd9:    r = AW'(64'sd8388597);
            5'd10:   r = AW'(64'sd4194303);
            default: r = AW'(1) <<< (6'd32 - {1'b0, i});
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/atmc_front.sv =====
// front end: accepts samples, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module atmc_front #(
    parameter int ACCEL_BITS = atmc_pkg::ACCEL_BITS_DEF,
    parameter int SAMPLES    = atmc_pkg::SAMPLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3*ACCEL_BITS-1:0]       s_xyz,
    output logic                          q_valid,
    input  logic                          q_pop,
    output atmc_pkg::item_kind_t          q_kind,
    output logic [3*ACCEL_BITS-1:0]       q_xyz
);
    import atmc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [1:0]              fill_reg, fill_next;
    logic                    wp_reg, rp_reg;
    item_kind_t              kind_q [2];
    logic [3*ACCEL_BITS-1:0] data_q [2];
    item_kind_t              in_kind;
    logic                    push;

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_kind  = kind_q[rp_reg];
    assign q_xyz   = data_q[rp_reg];

    always_comb begin
        if (done_reg) begin
            in_kind = K_HOLD;
        end else if (cnt_reg < CNT_W'(SAMPLES)) begin
            in_kind = K_STORE;
        end else begin
            in_kind = K_CALIB;
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (push && in_kind == K_STORE) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (push && in_kind == K_CALIB) begin
            done_next = 1'b1;
        end
        fill_next = fill_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            fill_reg <= 2'd0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            fill_reg <= fill_next;
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid) begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            kind_q[wp_reg] <= in_kind;
            data_q[wp_reg] <= s_xyz;
        end
    end

endmodule
`default_nettype wire

// ===== src/atmc_angle.sv =====
// angle engine: shared square root and cordic atan2 for roll, pitch and yaw
`timescale 1ns / 1ps
`default_nettype none
module atmc_angle #(
    parameter int ACCEL_BITS = atmc_pkg::ACCEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [ACCEL_BITS-1:0]  x_in,
    input  logic signed [ACCEL_BITS-1:0]  y_in,
    input  logic signed [ACCEL_BITS-1:0]  z_in,
    output logic                          done,
    output atmc_pkg::angle_set_t          result
);
    import atmc_pkg::*;

    localparam int H    = 32 - ACCEL_BITS;
    localparam int PW   = AW + 8;
    localparam int HALF = 1 << (FRAC_BITS - 1);

    // shift right, truncating toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input logic [4:0] sh);
        logic signed [CW-1:0] nv;
        nv = -v;
        if (!v[CW-1]) begin
            return v >>> sh;
        end
        return -(nv >>> sh);
    endfunction

    ang_state_t state_reg, state_next;
    ang_phase_t phase_reg;

    logic signed [ACCEL_BITS-1:0]   x_reg, y_reg, z_reg;
    logic [63:0]                    acc_reg, rem_reg, root_reg;
    logic [4:0]                     it_reg;
    logic signed [CW-1:0]           cx_reg, cy_reg;
    logic signed [AW-1:0]           ca_reg, adj_reg;
    logic signed [PW-1:0]           p_reg;
    logic signed [9:0]              roll_reg, pitch_reg, yaw_reg;

    logic signed [ACCEL_BITS-1:0]   sq_sel, opp;
    logic signed [2*ACCEL_BITS-1:0] sq_prod;
    logic [63:0]                    sq_sum, bitv, trial;
    logic signed [CW-1:0]           opp_s, ys, zs, cx_init, cy_init, dx, dy;
    logic signed [AW-1:0]           adj_init, step, v;
    logic signed [PW-1:0]           v_ext, p, mag, q;
    logic signed [9:0]              q10, cent;
    logic                           y_small, cz;

    always_comb begin
        sq_sel  = (state_reg == A_SQB) ? z_reg : ((phase_reg == PH_ROLL) ? x_reg : y_reg);
        sq_prod = sq_sel * sq_sel;
        sq_sum  = acc_reg + 64'(unsigned'(sq_prod));
        bitv    = 64'(1) << (6'd62 - {it_reg, 1'b0});
        trial   = root_reg + bitv;

        opp     = (phase_reg == PH_ROLL) ? y_reg : x_reg;
        opp_s   = CW'(opp) <<< H;
        ys      = CW'(y_reg) <<< H;
        zs      = CW'(z_reg) <<< H;
        y_small = (y_reg > -HALF) && (y_reg < HALF);

        if (phase_reg == PH_YAW) begin
            // negative z: fold into the right half plane, add back pi
            if (zs[CW-1]) begin
                cx_init  = -zs;
                cy_init  = -ys;
                adj_init = ys[CW-1] ? -PI_Q : PI_Q;
            end else begin
                cx_init  = zs;
                cy_init  = ys;
                adj_init = '0;
            end
        end else begin
            cx_init  = CW'(root_reg);
            cy_init  = opp_s;
            adj_init = '0;
        end
        cz = (cx_init == '0) && (cy_init == '0);

        dx   = shr_tz(cy_reg, it_reg);
        dy   = shr_tz(cx_reg, it_reg);
        step = atan_step(it_reg);

        case (phase_reg)
            PH_ROLL:  v = PI_Q - ca_reg;
            PH_PITCH: v = -ca_reg;
            default:  v = -(ca_reg + adj_reg);
        endcase
        v_ext = PW'(v);
        p     = (v_ext <<< 6) + (v_ext <<< 5) + (v_ext <<< 2);

        // round half away from zero
        mag  = p_reg[PW-1] ? -p_reg : p_reg;
        q    = (mag + (PW'(1) <<< 31)) >>> 32;
        q10  = q[9:0];
        cent = p_reg[PW-1] ? -q10 : q10;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE: begin
                if (start) begin
                    state_next = A_SQA;
                end
            end
            A_SQA:  state_next = A_SQB;
            A_SQB:  state_next = A_SQRT;
            A_SQRT: begin
                if (it_reg == 5'd31) begin
                    state_next = A_CSET;
                end
            end
            A_CSET: begin
                if (phase_reg == PH_YAW && y_small) begin
                    state_next = A_FIN;
                end else if (cz) begin
                    state_next = A_SCALE;
                end else begin
                    state_next = A_CORDIC;
                end
            end
            A_CORDIC: begin
                if (it_reg == 5'd31) begin
                    state_next = A_SCALE;
                end
            end
            A_SCALE: state_next = A_ROUND;
            A_ROUND: begin
                case (phase_reg)
                    PH_ROLL:  state_next = A_SQA;
                    PH_PITCH: state_next = A_CSET;
                    default:  state_next = A_FIN;
                endcase
            end
            A_FIN:   state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == A_FIN);
    end

    assign result = '{roll: roll_reg, pitch: pitch_reg, yaw: yaw_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            phase_reg <= PH_ROLL;
        end else begin
            state_reg <= state_next;
            if (state_reg == A_IDLE && start) begin
                phase_reg <= PH_ROLL;
            end else if (state_reg == A_ROUND) begin
                phase_reg <= (phase_reg == PH_ROLL) ? PH_PITCH : PH_YAW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: begin
                if (start) begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= z_in;
                end
            end
            A_SQA: acc_reg <= 64'(unsigned'(sq_prod));
            A_SQB: begin
                rem_reg  <= sq_sum << (2 * H);
                root_reg <= '0;
                it_reg   <= '0;
            end
            A_SQRT: begin
                if (rem_reg >= trial) begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                it_reg <= it_reg + 1'b1;
            end
            A_CSET: begin
                cx_reg  <= cx_init;
                cy_reg  <= cy_init;
                ca_reg  <= '0;
                adj_reg <= adj_init;
                it_reg  <= '0;
                if (phase_reg == PH_YAW && y_small) begin
                    yaw_reg <= '0;
                end
            end
            A_CORDIC: begin
                if (!cy_reg[CW-1]) begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    ca_reg <= ca_reg + step;
                end else begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    ca_reg <= ca_reg - step;
                end
                it_reg <= it_reg + 1'b1;
            end
            A_SCALE: p_reg <= p;
            A_ROUND: begin
                case (phase_reg)
                    PH_ROLL:  roll_reg  <= cent;
                    PH_PITCH: pitch_reg <= cent;
                    default:  yaw_reg   <= cent;
                endcase
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/atmc_median.sv =====
// angle store and median search by rank counting over the stored triples
`timescale 1ns / 1ps
`default_nettype none
module atmc_median #(
    parameter int SAMPLES = atmc_pkg::SAMPLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  atmc_pkg::med_ctrl_t   ctrl,
    input  atmc_pkg::angle_set_t  wr_data,
    output logic                  done,
    output atmc_pkg::angle_set_t  held
);
    import atmc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int IW    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CNT_W-1:0] K_HI = CNT_W'(SAMPLES / 2);
    localparam logic [CNT_W-1:0] K_LO = CNT_W'((SAMPLES % 2 == 0) ? SAMPLES / 2 - 1
                                                                 : SAMPLES / 2);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

    angle_set_t mem [SAMPLES];
    angle_set_t rdata_reg, cand_reg, held_reg;

    med_state_t state_reg, state_next;
    logic [CNT_W-1:0]  wp_reg, i_reg, j_reg;
    logic              cmp_v_reg;
    logic [CNT_W-1:0]  lt_reg [3];
    logic [CNT_W-1:0]  le_reg [3];
    logic signed [9:0] lo_reg [3];
    logic signed [9:0] hi_reg [3];
    logic signed [9:0] cand_f [3];
    logic signed [9:0] rd_f [3];
    logic [IW-1:0]     rd_addr;

    assign cand_f[0] = cand_reg.roll;
    assign cand_f[1] = cand_reg.pitch;
    assign cand_f[2] = cand_reg.yaw;
    assign rd_f[0]   = rdata_reg.roll;
    assign rd_f[1]   = rdata_reg.pitch;
    assign rd_f[2]   = rdata_reg.yaw;
    assign rd_addr   = (state_reg == M_RDC) ? i_reg[IW-1:0] : j_reg[IW-1:0];
    assign held      = held_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wp_reg[IW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: begin
                if (ctrl.start) begin
                    state_next = M_RDC;
                end
            end
            M_RDC: state_next = M_LDC;
            M_LDC: state_next = M_SWEEP;
            M_SWEEP: begin
                if (j_reg == LAST) begin
                    state_next = M_TAIL;
                end
            end
            M_TAIL: state_next = M_EVAL;
            M_EVAL: begin
                state_next = (i_reg == LAST) ? M_AVG : M_RDC;
            end
            M_AVG:   state_next = M_FIN;
            M_FIN:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == M_FIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            wp_reg    <= '0;
            held_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (ctrl.wr_en) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (state_reg == M_AVG) begin
                held_reg.roll  <= 10'(({lo_reg[0][9], lo_reg[0]} + {hi_reg[0][9], hi_reg[0]})
                                      >>> 1);
                held_reg.pitch <= 10'(({lo_reg[1][9], lo_reg[1]} + {hi_reg[1][9], hi_reg[1]})
                                      >>> 1);
                held_reg.yaw   <= 10'(({lo_reg[2][9], lo_reg[2]} + {hi_reg[2][9], hi_reg[2]})
                                      >>> 1);
            end
        end
    end

    // candidate i is the rank-k value when lt <= k < le
    always_ff @(posedge aclk) begin
        case (state_reg)
            M_IDLE: begin
                i_reg <= '0;
            end
            M_LDC: begin
                cand_reg  <= rdata_reg;
                j_reg     <= '0;
                cmp_v_reg <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    lt_reg[k] <= '0;
                    le_reg[k] <= '0;
                end
            end
            M_SWEEP, M_TAIL: begin
                j_reg     <= j_reg + 1'b1;
                cmp_v_reg <= (state_reg == M_SWEEP);
                if (cmp_v_reg) begin
                    for (int k = 0; k < 3; k++) begin
                        if (rd_f[k] < cand_f[k]) begin
                            lt_reg[k] <= lt_reg[k] + 1'b1;
                        end
                        if (rd_f[k] <= cand_f[k]) begin
                            le_reg[k] <= le_reg[k] + 1'b1;
                        end
                    end
                end
            end
            M_EVAL: begin
                i_reg <= i_reg + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (lt_reg[k] <= K_LO && K_LO < le_reg[k]) begin
                        lo_reg[k] <= cand_f[k];
                    end
                    if (lt_reg[k] <= K_HI && K_HI < le_reg[k]) begin
                        hi_reg[k] <= cand_f[k];
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/accel_tilt_median_calibrator_unit.sv =====
// top level: accelerometer tilt angles with one-time median calibration
//
//  channel  | ports                          | contents (low bit first)
//  ---------+--------------------------------+----------------------------------------
//  input    | s_tvalid s_tready s_tdata      | accel_x, accel_y, accel_z
//  result   | m_tvalid m_tready m_tdata      | roll, pitch, yaw_tilt; calibrated in m_tuser
//
//  a collecting sample is paced by the one shared square root and cordic engine (two
//  32-step roots and up to three 32-step atan2 runs; the yaw run is skipped when y is
//  in the yaw dead band)
//  the calibrating sample is paced by the single read port of the angle store; later
//  samples go straight to the result with the held medians
//  reset needs no clearing pass; the store is only read once completely written
//  a two-entry queue parts the input side from the back end, so input transfers
//  continue while a result waits on m_tready
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_median_calibrator_unit #(
    parameter int SAMPLES    = atmc_pkg::SAMPLES_DEF,
    parameter int ACCEL_BITS = atmc_pkg::ACCEL_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // accel_x, accel_y, accel_z, zero fill
    input  logic [((3*ACCEL_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // roll_centirad[8:0], pitch_centirad[17:9], yaw_tilt_centirad[27:18], zero fill
    output logic [31:0]                           m_tdata,
    // calibrated
    output logic [0:0]                            m_tuser
);
    import atmc_pkg::*;

    logic                    q_valid, q_pop;
    item_kind_t              q_kind;
    logic [3*ACCEL_BITS-1:0] q_xyz;
    logic                    ang_start, ang_done, med_done;
    angle_set_t              ang_res, held;
    med_ctrl_t               med_ctrl;
    back_state_t             state_reg, state_next;
    logic                    out_load, out_from_held;
    angle_set_t              out_set_reg;
    logic                    cal_reg;

    atmc_front #(
        .ACCEL_BITS(ACCEL_BITS),
        .SAMPLES   (SAMPLES)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_tvalid),
        .s_ready(s_tready),
        .s_xyz  (s_tdata[3*ACCEL_BITS-1:0]),
        .q_valid(q_valid),
        .q_pop  (q_pop),
        .q_kind (q_kind),
        .q_xyz  (q_xyz)
    );

    atmc_angle #(
        .ACCEL_BITS(ACCEL_BITS)
    ) u_angle (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (ang_start),
        .x_in   (signed'(q_xyz[ACCEL_BITS-1:0])),
        .y_in   (signed'(q_xyz[2*ACCEL_BITS-1:ACCEL_BITS])),
        .z_in   (signed'(q_xyz[3*ACCEL_BITS-1:2*ACCEL_BITS])),
        .done   (ang_done),
        .result (ang_res)
    );

    atmc_median #(
        .SAMPLES(SAMPLES)
    ) u_median (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (med_ctrl),
        .wr_data(ang_res),
        .done   (med_done),
        .held   (held)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_kind)
                        K_STORE: state_next = B_ANGLE;
                        K_CALIB: state_next = B_MEDIAN;
                        default: state_next = B_OUT;
                    endcase
                end
            end
            B_ANGLE: begin
                if (ang_done) begin
                    state_next = B_OUT;
                end
            end
            B_MEDIAN: begin
                if (med_done) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (m_tready) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop          = 1'b0;
        ang_start      = 1'b0;
        med_ctrl       = '0;
        out_load       = 1'b0;
        out_from_held  = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_kind)
                        K_STORE: ang_start = 1'b1;
                        K_CALIB: med_ctrl.start = 1'b1;
                        default: begin
                            out_load      = 1'b1;
                            out_from_held = 1'b1;
                        end
                    endcase
                end
            end
            B_ANGLE: begin
                if (ang_done) begin
                    med_ctrl.wr_en = 1'b1;
                    out_load       = 1'b1;
                end
            end
            B_MEDIAN: begin
                if (med_done) begin
                    out_load      = 1'b1;
                    out_from_held = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_set_reg <= out_from_held ? held : ang_res;
            cal_reg     <= out_from_held;
        end
    end

    assign m_tvalid = (state_reg == B_OUT);
    assign m_tdata  = {4'd0, out_set_reg.yaw, out_set_reg.pitch[8:0], out_set_reg.roll[8:0]};
    assign m_tuser  = cal_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the accelerometer tilt calibrator: predicts tilt angles and medians
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int  NSAMP      = 99;
    localparam int  RAND_ITEMS = 980;
    localparam int  CYCLE_MAX  = 1000000;
    localparam longint PI_FX   = 64'sd13493037705;

    typedef struct packed {
        logic [8:0] roll;
        logic [8:0] pitch;
        logic [9:0] yaw;
        logic       cal;
    } tilt_t;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } accel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    accel_t pending_q[$];
    tilt_t  angle_q[$];
    int     n_sent = 0;
    int     n_fail = 0;
    int     cycles = 0;
    bit     holdoff_done = 1'b0;

    // calibrator state mirror
    int     roll_buf[NSAMP];
    int     pitch_buf[NSAMP];
    int     yaw_buf[NSAMP];
    int     n_stored = 0;
    bit     locked = 1'b0;
    int     med_roll = 0, med_pitch = 0, med_yaw = 0;

    accel_tilt_median_calibrator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic longint shr_trunc(longint v, int i);
        return (v >= 0) ? (v >>> i) : -((-v) >>> i);
    endfunction

    function automatic longint atan_pow2(int i);
        case (i)
            0: return 64'sd3373259426;
            1: return 64'sd1991351318;
            2: return 64'sd1052175346;
            3: return 64'sd534100635;
            4: return 64'sd268086748;
            5: return 64'sd134174063;
            6: return 64'sd67103403;
            7: return 64'sd33553749;
            8: return 64'sd16777131;
            9: return 64'sd8388597;
            10: return 64'sd4194303;
            default: return 64'sd1 <<< (32 - i);
        endcase
    endfunction

    function automatic longint vector_atan(longint yv, longint xv);
        longint cx, cy, acc, dx, dy;
        cx = xv; cy = yv; acc = 0;
        if (xv == 0 && yv == 0) return 0;
        for (int i = 0; i < 32; i++) begin
            dx = shr_trunc(cy, i);
            dy = shr_trunc(cx, i);
            if (cy >= 0) begin
                cx += dx; cy -= dy; acc += atan_pow2(i);
            end else begin
                cx -= dx; cy += dy; acc -= atan_pow2(i);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint centirad(longint ang);
        longint p, mag, q;
        p = ang * 100;
        mag = (p < 0) ? -p : p;
        q = (mag + (64'sd1 <<< 31)) >>> 32;
        return (p < 0) ? -q : q;
    endfunction

    // atan2(opp, sqrt(a^2 + b^2)) at 16-bit input scaling
    function automatic longint elev_angle(longint opp, longint a, longint b);
        longint unsigned sq;
        sq = longint'(a * a + b * b);
        sq = sq << 32;
        return vector_atan(opp <<< 16, longint'(root_floor(sq)));
    endfunction

    function automatic int median_of(int src[NSAMP]);
        int t[NSAMP];
        int v, j, s;
        t = src;
        for (int i = 1; i < NSAMP; i++) begin
            v = t[i];
            j = i - 1;
            while (j >= 0 && t[j] > v) begin
                t[j + 1] = t[j];
                j--;
            end
            t[j + 1] = v;
        end
        if (NSAMP % 2 != 0) return t[NSAMP / 2];
        s = t[NSAMP / 2] + t[NSAMP / 2 - 1];
        return (s >= 0) ? s / 2 : (s - 1) / 2;
    endfunction

    function automatic tilt_t predict_tilt(accel_t a);
        longint x, y, z, r, p, w, ang;
        tilt_t o;
        r = med_roll; p = med_pitch; w = med_yaw;
        o.cal = 1'b1;
        if (!locked) begin
            x = longint'(signed'(a.x));
            y = longint'(signed'(a.y));
            z = longint'(signed'(a.z));
            r = centirad(PI_FX - elev_angle(y, x, z));
            p = -centirad(elev_angle(x, y, z));
            if (y > -128 && y < 128) begin
                w = 0;
            end else begin
                if (z >= 0) ang = vector_atan(y <<< 16, z <<< 16);
                else ang = vector_atan(-(y <<< 16), -(z <<< 16)) + ((y >= 0) ? PI_FX : -PI_FX);
                w = -centirad(ang);
            end
            if (n_stored < NSAMP) begin
                roll_buf[n_stored] = int'(r);
                pitch_buf[n_stored] = int'(p);
                yaw_buf[n_stored] = int'(w);
                n_stored++;
                o.cal = 1'b0;
            end else begin
                locked = 1'b1;
                med_roll = median_of(roll_buf);
                med_pitch = median_of(pitch_buf);
                med_yaw = median_of(yaw_buf);
                r = med_roll; p = med_pitch; w = med_yaw;
            end
        end
        o.roll = r[8:0];
        o.pitch = p[8:0];
        o.yaw = w[9:0];
        return o;
    endfunction

    function automatic logic [15:0] rand_axis(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(255) - 128);
            2: return 16'($urandom_range(8000) - 4000);
            default: return 16'($urandom_range(2) - 1);
        endcase
    endfunction

    function automatic void add_item(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        accel_t a;
        a.x = x; a.y = y; a.z = z;
        pending_q.push_back(a);
    endfunction

    // driver: idle pattern follows the phase given by the transfer count
    always @(posedge aclk) begin
        int phase;
        bit idle;
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                angle_q.push_back(predict_tilt(accel_t'(s_tdata)));
                n_sent = n_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                phase = (n_sent / 250) % 4;
                idle = (phase == 1 && $urandom_range(99) < 85)
                    || (phase == 3 && $urandom_range(99) < 26);
                if (n_sent == 60 && !holdoff_done) begin
                    if (angle_q.size() != 0) idle = 1'b1;
                    else holdoff_done = 1'b1;
                end
                if (pending_q.size() != 0 && !idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: result stall pattern and field compare
    always @(posedge aclk) begin
        int phase;
        tilt_t want;
        phase = (n_sent / 250) % 4;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !((phase == 2 && $urandom_range(99) < 85)
                || (phase == 3 && $urandom_range(99) < 26));
            if (m_tvalid && m_tready) begin
                if (angle_q.size() == 0) begin
                    $error("result transfer with nothing expected: tdata=%h", m_tdata);
                    n_fail++;
                end else begin
                    want = angle_q.pop_front();
                    if (m_tdata[8:0] !== want.roll) begin
                        $error("roll_centirad exp %0d got %0d", want.roll, m_tdata[8:0]);
                        n_fail++;
                    end
                    if (m_tdata[17:9] !== want.pitch) begin
                        $error("pitch_centirad exp %h got %h", want.pitch, m_tdata[17:9]);
                        n_fail++;
                    end
                    if (m_tdata[27:18] !== want.yaw) begin
                        $error("yaw_tilt_centirad exp %h got %h", want.yaw, m_tdata[27:18]);
                        n_fail++;
                    end
                    if (m_tuser[0] !== want.cal) begin
                        $error("calibrated exp %0d got %0d", want.cal, m_tuser[0]);
                        n_fail++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_MAX) begin
            $display("accel_tilt_median_calibrator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int mode;
        // axis extremes, zero vector, yaw dead band edges, negative z both signs of y
        add_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_item(16'h8000, 16'h8000, 16'h8000);
        add_item(16'h0000, 16'h0000, 16'h0000);
        add_item(16'h0000, 16'h0000, 16'h0A00);
        add_item(16'h7FFF, 16'h0000, 16'h0000);
        add_item(16'h8000, 16'h0000, 16'h0000);
        add_item(16'h0000, 16'h7FFF, 16'h0000);
        add_item(16'h0000, 16'h8000, 16'h0000);
        add_item(16'h0000, 16'h0000, 16'h8000);
        add_item(16'h0100, 16'd127, 16'h0900);
        add_item(16'h0100, -16'sd127, 16'h0900);
        add_item(16'h0100, 16'd128, 16'h0900);
        add_item(16'h0100, -16'sd128, 16'h0900);
        add_item(16'h0040, 16'h0300, 16'hF700);
        add_item(16'h0040, 16'hFD00, 16'hF700);
        add_item(16'h0000, 16'h0080, 16'h8000);
        add_item(16'h0000, 16'hFF80, 16'h8000);
        add_item(16'h0000, 16'h0200, 16'h0000);
        add_item(16'h0000, 16'hFE00, 16'h0000);
        add_item(16'h5555, 16'hAAAA, 16'h5555);
        add_item(16'hAAAA, 16'h5555, 16'hAAAA);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            mode = $urandom_range(9);
            if (mode < 4)
                add_item(rand_axis(0), rand_axis(0), rand_axis(0));
            else if (mode < 7)
                add_item(rand_axis(2), rand_axis(2), rand_axis(2));
            else if (mode < 9)
                add_item(rand_axis(2), rand_axis(1), rand_axis(2));
            else
                add_item(rand_axis(3), rand_axis(3), rand_axis(3));
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_q.size() == 0 && !s_tvalid);
        wait (angle_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (n_fail == 0) begin
            $display("accel_tilt_median_calibrator_unit: match");
        end else begin
            $display("accel_tilt_median_calibrator_unit: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/atmc_pkg.sv
src/atmc_front.sv
src/atmc_angle.sv
src/atmc_median.sv
src/accel_tilt_median_calibrator_unit.sv
tb/tb.sv
